// ----- src/mcel_pkg.sv -----
package mcel_pkg;

    localparam int MAX_CLASSES    = 1024;
    localparam int PROB_FRAC_BITS = 24;
    localparam int LOG_TABLE_BITS = 8;

    localparam int PROB_W      = PROB_FRAC_BITS + 1;
    localparam int CLASS_W     = $clog2(MAX_CLASSES);
    localparam int NUM_CLASS_W = 11;
    localparam int LOSS_W      = 32;
    localparam int LZ_W        = $clog2(PROB_W);
    localparam int TABLE_SIZE  = 2 ** LOG_TABLE_BITS;

    localparam logic [LOSS_W-1:0] LN2_Q16  = 32'd45426;
    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    // Probability floor: round(1e-7 * 2^PROB_FRAC_BITS), at least one LSB
    localparam longint FLOOR_CALC  = ((64'd1 << PROB_FRAC_BITS) + 64'd5000000) / 64'd10000000;
    localparam longint FLOOR_VAL   = (FLOOR_CALC < 1) ? 1 : FLOOR_CALC;
    localparam logic [PROB_W-1:0] PROB_FLOOR = PROB_W'(FLOOR_VAL);
    localparam logic [PROB_W-1:0] PROB_ONE   = PROB_W'(1) << PROB_FRAC_BITS;

    // Register map
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_NUM_CLASSES = 1'b0;
    localparam logic [NUM_CLASS_W-1:0] NUM_CLASSES_RESET = 11'd10;

    typedef struct packed {
        logic [PROB_W-1:0]  prob;
        logic [CLASS_W-1:0] target_class;
        logic               row_kept;
        logic               last_in_batch;
    } in_item_t;

    typedef struct packed {
        logic [LOSS_W-1:0] total_loss;
        logic              loss_saturated;
    } out_item_t;

    typedef logic [LOSS_W-1:0] ln_table_t [TABLE_SIZE];

    // Restoring division, evaluated only while building the constant table
    function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // T[i] ~ ln(1 + i/2^LOG_TABLE_BITS) in Q16.16, via the atanh series
    function automatic ln_table_t build_ln_table();
        ln_table_t   t;
        logic [63:0] y;
        logic [63:0] pw;
        logic [63:0] s;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            y  = const_udiv(64'(i) << 32, (64'd1 << (LOG_TABLE_BITS + 1)) + 64'(i));
            pw = y;
            s  = y;
            for (int n = 3; n <= 41; n += 2)
            begin
                pw = (pw * y) >> 32;
                pw = (pw * y) >> 32;
                s  = s + const_udiv(pw, 64'(n));
            end
            t[i] = LOSS_W'(((s << 1) + 64'd32768) >> 16);
        end
        return t;
    endfunction

    localparam ln_table_t LN_TABLE = build_ln_table();

endpackage

// ----- src/mcel_neg_ln.sv -----
module mcel_neg_ln
    import mcel_pkg::*;
(
    input  logic [PROB_W-1:0] prob,
    output logic [LOSS_W-1:0] neg_ln
);

    logic [PROB_W-1:0]         p_clamped;
    logic [LZ_W-1:0]           lead;
    logic [LZ_W-1:0]           expo;
    logic [PROB_W-1:0]         p_shifted;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [LOSS_W-1:0]         expo_term;

    // Clamp into [floor, 1.0]
    always_comb
    begin
        if (prob > PROB_ONE)
            p_clamped = PROB_ONE;
        else if (prob < PROB_FLOOR)
            p_clamped = PROB_FLOOR;
        else
            p_clamped = prob;
    end

    // Position of the leading one
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < PROB_W; i++)
        begin
            if (p_clamped[i])
                lead = LZ_W'(i);
        end
    end

    // Mantissa bits just below the leading one, zero-filled on the right
    always_comb
    begin
        if (lead >= LZ_W'(LOG_TABLE_BITS))
            p_shifted = p_clamped >> (lead - LZ_W'(LOG_TABLE_BITS));
        else
            p_shifted = p_clamped << (LZ_W'(LOG_TABLE_BITS) - lead);
        idx = p_shifted[LOG_TABLE_BITS-1:0];
    end

    assign expo      = LZ_W'(PROB_FRAC_BITS) - lead;
    assign expo_term = LOSS_W'(expo) * LN2_Q16;
    assign neg_ln    = expo_term - LN_TABLE[idx];

endmodule

// ----- src/masked_cross_entropy_loss_sum_core.sv -----
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      in_item_t: prob, target_class, row_kept,
//                                                   last_in_batch
// result    out        result_valid / result_ready  out_item_t: total_loss, loss_saturated
// config    in         APB psel/penable/pwrite      num_classes at byte address 0
//
// One item is taken per cycle unless the pipe is held. An item passes an input
// register, a register that holds its -ln(p) contribution, and then reaches the
// accumulator; result_valid is set as the batch's last item leaves that second register.
// The accumulator add is the only loop; the log path is stateless.
// rst_n clears counters, accumulator, flag and all valid bits; num_classes returns to 10.
// Items keep flowing while a total waits; the pipe holds only when a second
// total is ready and the previous one has not been taken.
module masked_cross_entropy_loss_sum_core
    import mcel_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_ready,
    input  in_item_t           item,

    output logic               result_valid,
    input  logic               result_ready,
    output out_item_t          result,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [NUM_CLASS_W-1:0] num_classes_reg;
    logic [NUM_CLASS_W-1:0] eff_classes;
    logic [CLASS_W-1:0]     class_pos_reg;
    logic [CLASS_W-1:0]     class_pos_next;
    logic [NUM_CLASS_W-1:0] class_pos_inc;

    logic                   advance;
    logic                   accept;

    logic                   s1_valid_reg;
    logic [PROB_W-1:0]      s1_prob_reg;
    logic                   s1_hit_reg;
    logic                   s1_last_reg;

    logic [LOSS_W-1:0]      neg_ln;

    logic                   s2_valid_reg;
    logic [LOSS_W-1:0]      s2_contrib_reg;
    logic                   s2_last_reg;

    logic [LOSS_W-1:0]      acc_reg;
    logic                   ovf_reg;
    logic [LOSS_W:0]        sum_wide;
    logic [LOSS_W-1:0]      sum_sat;
    logic                   sum_ovf;

    logic                   result_valid_reg;
    out_item_t              result_reg;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_classes_reg <= NUM_CLASSES_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_NUM_CLASSES))
            num_classes_reg <= pwdata[NUM_CLASS_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_NUM_CLASSES)
            prdata = 32'(num_classes_reg);
        else
            prdata = '0;
    end

    // Row length clamped to [1, MAX_CLASSES]
    always_comb
    begin
        if (num_classes_reg == '0)
            eff_classes = NUM_CLASS_W'(1);
        else if (num_classes_reg > NUM_CLASS_W'(MAX_CLASSES))
            eff_classes = NUM_CLASS_W'(MAX_CLASSES);
        else
            eff_classes = num_classes_reg;
    end

    // ---------------------------------------------------------------- flow
    // Hold everything only when a total is due and the result register is still full
    assign advance    = !(s2_valid_reg && s2_last_reg && result_valid_reg && !result_ready);
    assign item_ready = advance;
    assign accept     = item_valid && advance;

    // Column counter: wrap at the row length, restart at batch end
    assign class_pos_inc = NUM_CLASS_W'(class_pos_reg) + NUM_CLASS_W'(1);

    always_comb
    begin
        if (item.last_in_batch || (class_pos_inc >= eff_classes))
            class_pos_next = '0;
        else
            class_pos_next = class_pos_inc[CLASS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            class_pos_reg <= '0;
        else if (accept)
            class_pos_reg <= class_pos_next;
    end

    // ---------------------------------------------------------------- stage 1
    // Capture the item and decide whether it carries the target-class probability
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prob_reg <= item.prob;
            s1_hit_reg  <= item.row_kept && (class_pos_reg == item.target_class);
            s1_last_reg <= item.last_in_batch;
        end
    end

    // ---------------------------------------------------------------- stage 2
    mcel_neg_ln u_neg_ln
    (
        .prob   (s1_prob_reg),
        .neg_ln (neg_ln)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    // Drop the contribution of rows that do not count
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_contrib_reg <= s1_hit_reg ? neg_ln : '0;
            s2_last_reg    <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------- accumulate
    assign sum_wide = {1'b0, acc_reg} + {1'b0, s2_contrib_reg};
    assign sum_ovf  = sum_wide[LOSS_W];
    assign sum_sat  = sum_ovf ? LOSS_MAX : sum_wide[LOSS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (advance && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= sum_sat;
                ovf_reg <= ovf_reg | sum_ovf;
            end
        end
    end

    // Load the batch total, including the last item's share
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance && s2_valid_reg && s2_last_reg)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg && s2_last_reg)
        begin
            result_reg.total_loss     <= sum_sat;
            result_reg.loss_saturated <= ovf_reg | sum_ovf;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/masked_cross_entropy_loss_sum_core_tb.sv -----
`timescale 1ns / 1ps

module masked_cross_entropy_loss_sum_core_tb;
    import mcel_pkg::*;

    // Own fixed-point constants for the loss predictor
    localparam logic [PROB_W-1:0] PROB_UNIT  = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [PROB_W-1:0] PROB_MAX   = '1;
    localparam longint            FLOOR_RND  = ((64'd1 << PROB_FRAC_BITS) + 64'd5000000)
                                               / 64'd10000000;
    localparam logic [PROB_W-1:0] PROB_MIN   = (FLOOR_RND < 1) ? PROB_W'(1)
                                                               : PROB_W'(FLOOR_RND);
    localparam logic [31:0]       LN2_FIX    = 32'd45426;
    localparam int                LOG_ROWS   = 2 ** LOG_TABLE_BITS;
    localparam int                ROW_LIMIT  = MAX_CLASSES;

    // Register address of num_classes (register 0, word aligned)
    localparam logic [PADDR_W-1:0] NUM_CLASSES_ADDR = {REG_NUM_CLASSES, 2'b00};

    // Tracks the batch loss the block should report and checks each total
    class loss_scoreboard;
        logic [NUM_CLASS_W-1:0] cfg_num_classes;
        logic [CLASS_W-1:0]     col;
        logic [LOSS_W-1:0]      acc;
        logic                   sat;
        logic [31:0]            ln_q16 [LOG_ROWS];
        out_item_t              totals_due [$];
        int                     errors;

        function new();
            logic [63:0] y;
            logic [63:0] pw;
            logic [63:0] s;
            for (int i = 0; i < LOG_ROWS; i++)
            begin
                // atanh series: ln(1 + x) = 2 * atanh(x / (2 + x))
                y  = (64'(i) << 32) / ((64'd1 << (LOG_TABLE_BITS + 1)) + 64'(i));
                pw = y;
                s  = y;
                for (int n = 3; n <= 41; n += 2)
                begin
                    pw = (pw * y) >> 32;
                    pw = (pw * y) >> 32;
                    s  = s + pw / 64'(n);
                end
                ln_q16[i] = 32'(((s << 1) + 64'd32768) >> 16);
            end
            cfg_num_classes = 11'd10;
            col             = '0;
            acc             = '0;
            sat             = 1'b0;
            errors          = 0;
        endfunction

        // -ln(p) in Q16.16 with p clamped to [floor, 1.0]
        function logic [31:0] neg_ln(logic [PROB_W-1:0] p);
            int                        k;
            logic [LOG_TABLE_BITS-1:0] idx;
            logic [63:0]               wide;
            if (p > PROB_UNIT)
                p = PROB_UNIT;
            if (p < PROB_MIN)
                p = PROB_MIN;
            k = 0;
            for (int b = 0; b < PROB_W; b++)
                if (p[b])
                    k = b;
            wide = 64'(p);
            if (k >= LOG_TABLE_BITS)
                idx = LOG_TABLE_BITS'(wide >> (k - LOG_TABLE_BITS));
            else
                idx = LOG_TABLE_BITS'(wide << (LOG_TABLE_BITS - k));
            return 32'(PROB_FRAC_BITS - k) * LN2_FIX - ln_q16[idx];
        endfunction

        function int row_len();
            int eff;
            eff = int'(cfg_num_classes);
            if (eff < 1)
                eff = 1;
            if (eff > ROW_LIMIT)
                eff = ROW_LIMIT;
            return eff;
        endfunction

        function void note_item(in_item_t it);
            logic [LOSS_W:0] sum;
            if (it.row_kept && col == it.target_class)
            begin
                sum = {1'b0, acc} + {1'b0, neg_ln(it.prob)};
                if (sum > {1'b0, LOSS_MAX})
                begin
                    sum = {1'b0, LOSS_MAX};
                    sat = 1'b1;
                end
                acc = sum[LOSS_W-1:0];
            end
            // wrap as soon as the next column reaches the current row length
            if (int'(col) + 1 >= row_len())
                col = '0;
            else
                col = col + 1'b1;
            if (it.last_in_batch)
            begin
                totals_due.push_back('{total_loss: acc, loss_saturated: sat});
                acc = '0;
                sat = 1'b0;
                col = '0;
            end
        endfunction

        function void check_total(out_item_t got);
            out_item_t want;
            if (totals_due.size() == 0)
            begin
                errors++;
                $display("%0t: total with none pending: expected none, actual loss=%h sat=%b",
                         $time, got.total_loss, got.loss_saturated);
            end
            else
            begin
                want = totals_due.pop_front();
                if (got.total_loss !== want.total_loss)
                begin
                    errors++;
                    $display("%0t: total_loss mismatch: expected %h, actual %h",
                             $time, want.total_loss, got.total_loss);
                end
                if (got.loss_saturated !== want.loss_saturated)
                begin
                    errors++;
                    $display("%0t: loss_saturated mismatch: expected %b, actual %b",
                             $time, want.loss_saturated, got.loss_saturated);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    in_item_t           item;
    logic               result_valid;
    logic               result_ready;
    out_item_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    loss_scoreboard sb;
    bit             idle_on;
    int             items_sent;

    masked_cross_entropy_loss_sum_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 600 items with full gaps)
    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic in_item_t mk_item(input logic [PROB_W-1:0] p, input int tc,
                                         input bit kept, input bit last);
        in_item_t it;
        it.prob          = p;
        it.target_class  = CLASS_W'(tc);
        it.row_kept      = kept;
        it.last_in_batch = last;
        return it;
    endfunction

    // Mix of floor-range, short-mantissa, near-one, above-one and general probabilities
    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 5))
            0:       return PROB_W'($urandom_range(0, 3));
            1:       return PROB_W'($urandom_range(0, 511));
            2:       return PROB_W'($urandom_range(int'(PROB_UNIT) - 4096, int'(PROB_UNIT)));
            3:       return PROB_W'($urandom_range(0, int'(PROB_MAX)));
            default: return PROB_W'($urandom_range(1, int'(PROB_UNIT)));
        endcase
    endfunction

    // Offer one item; hold valid and payload until the block takes it
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Drop valid, wait for every pending total, then let trailing items clear the pipe
    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.totals_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_num_classes(input logic [NUM_CLASS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NUM_CLASSES_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[NUM_CLASS_W-1:0] !== value)
        begin
            sb.errors++;
            $display("%0t: num_classes read-back mismatch: expected %h, actual %h",
                     $time, value, prdata[NUM_CLASS_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.cfg_num_classes = value;
    endtask

    // Random traffic: mostly whole rows with one target class each, plus noise and cut batches
    task automatic run_random_phase(input int budget);
        int eff;
        int rows;
        int tc;
        int len;
        int style;
        int sent;
        bit kept;
        eff  = sb.row_len();
        sent = 0;
        while (sent < budget)
        begin
            style = $urandom_range(0, 9);
            if (style < 7)
            begin
                rows = $urandom_range(1, 3);
                for (int r = 0; r < rows; r++)
                begin
                    tc   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, eff - 1);
                    kept = ($urandom_range(0, 3) != 0);
                    for (int c = 0; c < eff; c++)
                    begin
                        send_item(mk_item(rand_prob(), tc, kept,
                                          (r == rows - 1) && (c == eff - 1)));
                        sent++;
                    end
                end
            end
            else if (style < 9)
            begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                begin
                    tc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 3);
                    send_item(mk_item(PROB_W'($urandom_range(0, int'(PROB_MAX))), tc,
                                      1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0));
                    sent++;
                end
            end
            else
            begin
                // batch cut short in the middle of a row
                len = $urandom_range(1, eff);
                tc  = $urandom_range(0, eff - 1);
                for (int j = 0; j < len; j++)
                begin
                    send_item(mk_item(rand_prob(), tc, 1'b1, j == len - 1));
                    sent++;
                end
            end
        end
    endtask

    // Result side: check on every accepted total, stall in random bursts
    initial
    begin
        int stall;
        stall        = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_total(result);
            if (stall > 0)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(0, 4);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [PROB_W-1:0]      edge_probs [9];
        logic [NUM_CLASS_W-1:0] row_choices [9];
        int                     tc;
        int                     rnd_items0;

        sb         = new();
        idle_on    = 1'b1;
        items_sent = 0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset row length of 10: the target class sits on the last column, and the
        // row fields on other columns differ to show they are ignored there
        for (int c = 0; c < 10; c++)
        begin
            if (c == 9)
                send_item(mk_item(PROB_W'(12345678), 9, 1'b1, 1'b1));
            else
                send_item(mk_item((c == 4) ? PROB_UNIT + 5 : rand_prob(), (c + 1) % 10,
                                  c[0], 1'b0));
        end
        // Leave the column counter at 3, then shrink the row under it
        for (int c = 0; c < 3; c++)
            send_item(mk_item(rand_prob(), 7, 1'b1, 1'b0));
        drain();
        write_num_classes(11'd2);
        send_item(mk_item(PROB_UNIT - 1, 0, 1'b1, 1'b0));
        send_item(mk_item(PROB_W'(1000), 1, 1'b0, 1'b1));
        drain();

        // One element per row: every element is its row's target class
        write_num_classes(11'd1);
        edge_probs = '{PROB_W'(0), PROB_W'(1), PROB_MIN, PROB_W'(3), PROB_W'(255),
                       PROB_W'(256), PROB_UNIT, PROB_UNIT + 1, PROB_MAX};
        foreach (edge_probs[i])
            send_item(mk_item(edge_probs[i], 0, 1'b1, i[0]));
        send_item(mk_item(PROB_W'(7), 1023, 1'b1, 1'b0));   // target class past the row
        send_item(mk_item(PROB_W'(7), 0, 1'b0, 1'b1));      // row not kept
        drain();

        // Random part: new row length per phase, mostly short rows
        row_choices = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd7, 11'd10, 11'd16, 11'd0, 11'd12};
        rnd_items0  = items_sent;
        while (items_sent - rnd_items0 < 470)
        begin
            if ($urandom_range(0, 4) == 0)
                write_num_classes(NUM_CLASS_W'($urandom_range(1, 40)));
            else
            begin
                tc = $urandom_range(0, 8);
                write_num_classes(row_choices[tc]);
            end
            // hold back idling for the closing stretch
            if (items_sent - rnd_items0 >= 420)
                idle_on = 1'b0;
            run_random_phase($urandom_range(40, 80));
            drain();
        end

        idle_on = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.totals_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
